### rtl/mpsm_pkg.sv
// Shared types and constants for the multi-pattern substring matcher.
// Holds the fixed pattern tables and the case folding function; no dependencies.
`timescale 1ns / 1ps

package mpsm_pkg;

   // default window length and the widths of the fields
   localparam int MAX_PATTERN_LEN_DEF = 15;
   localparam int CHAR_W              = 8;
   localparam int PAT_COUNT           = 6;
   localparam int PAT_TEXT_MAX        = 16;
   localparam int PAT_LEN_W           = 5;
   localparam int LIST_COUNT          = 2;

   typedef logic [CHAR_W-1:0]    char_type;
   typedef logic [PAT_COUNT-1:0] pat_mask_type;

   // list codes
   localparam logic LIST_NAME = 1'b0;
   localparam logic LIST_PATH = 1'b1;

   // pattern lengths in bytes
   localparam logic [PAT_LEN_W-1:0] PAT_LEN [PAT_COUNT] = '{
      5'd5, 5'd11, 5'd5, 5'd5, 5'd9, 5'd15
   };

   // pattern text, lower case ascii, first character at index 0, zero padded
   localparam char_type PAT_TEXT [PAT_COUNT][PAT_TEXT_MAX] = '{
      '{8'h66, 8'h72, 8'h69, 8'h64, 8'h61, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
      '{8'h67, 8'h75, 8'h6d, 8'h2d, 8'h6a, 8'h73, 8'h2d, 8'h6c,
        8'h6f, 8'h6f, 8'h70, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
      '{8'h67, 8'h6d, 8'h61, 8'h69, 8'h6e, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
      '{8'h67, 8'h64, 8'h62, 8'h75, 8'h73, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
      '{8'h6c, 8'h69, 8'h6e, 8'h6a, 8'h65, 8'h63, 8'h74, 8'h6f,
        8'h72, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
      '{8'h72, 8'h65, 8'h2e, 8'h66, 8'h72, 8'h69, 8'h64, 8'h61,
        8'h2e, 8'h73, 8'h65, 8'h72, 8'h76, 8'h65, 8'h72, 8'h00}
   };

   // membership of each pattern in the name and path lists
   localparam pat_mask_type LIST_MASK [LIST_COUNT] = '{6'h3F, 6'h31};

   // ascii upper case to lower case, everything else unchanged
   function automatic char_type fold_char(input char_type c);
      char_type r;
      r = c;
      if (c >= 8'h41 && c <= 8'h5A) begin
         r = c + 8'h20;
      end
      return r;
   endfunction

endpackage

### rtl/mpsm_req_if.sv
// Request and response channel interfaces of the substring matcher.
// Depends on mpsm_pkg for the character type.
`timescale 1ns / 1ps

interface mpsm_req_if;
   import mpsm_pkg::*;

   logic     valid;
   logic     ready;
   char_type char_code;
   logic     is_last;
   logic     list_select;

   modport source (output valid, output char_code, output is_last, output list_select,
                   input ready);
   modport sink   (input valid, input char_code, input is_last, input list_select,
                   output ready);
endinterface

interface mpsm_rsp_if;
   logic valid;
   logic ready;
   logic matched;

   modport source (output valid, output matched, input ready);
   modport sink   (input valid, input matched, output ready);
endinterface

### rtl/multi_pattern_substring_matcher.sv
// Request bytes pass the input register; results pass the result register.
// Throughput: one byte per cycle; all pattern comparators run in parallel on a
// shift-register window, and a waiting result only stalls a last byte.
// Reset: synchronous, active high; clears valids, character count and hit flag.
// Depends on mpsm_pkg, mpsm_req_if / mpsm_rsp_if and mpsm_match.
`timescale 1ns / 1ps

module multi_pattern_substring_matcher
   import mpsm_pkg::*;
#(
   parameter int MAX_PATTERN_LEN = MAX_PATTERN_LEN_DEF
) (
   input  logic         clock,
   input  logic         reset,
   mpsm_req_if.sink     req,
   mpsm_rsp_if.source   rsp
);

   localparam int CNT_W = $clog2(MAX_PATTERN_LEN + 1);

   // input stage
   logic     s1_valid_ff, s1_valid_in;
   char_type s1_char_ff;
   logic     s1_last_ff;
   logic     s1_sel_ff;

   // string state
   logic [MAX_PATTERN_LEN-2:0][CHAR_W-1:0] hist_ff, hist_in;
   logic [CNT_W-1:0]                       count_ff, count_in;
   logic                                   hit_ff, hit_in;

   // result register
   logic out_valid_ff, out_valid_in;
   logic out_matched_ff, out_matched_in;

   logic [MAX_PATTERN_LEN-1:0][CHAR_W-1:0] win_cur;
   logic [CNT_W-1:0]                       count_next;
   logic                                   match;
   logic                                   advance;
   logic                                   req_take;

   // handshake: a last byte needs a free result slot
   assign advance  = s1_valid_ff && (!s1_last_ff || !out_valid_ff || rsp.ready);
   assign req.ready = !s1_valid_ff || advance;
   assign req_take = req.valid && req.ready;

   // window including the byte being processed
   assign win_cur    = {hist_ff, s1_char_ff};
   assign count_next = (count_ff == CNT_W'(MAX_PATTERN_LEN)) ? count_ff
                                                            : count_ff + 1'b1;

   mpsm_match #(
      .MAX_PATTERN_LEN (MAX_PATTERN_LEN)
   ) u_match (
      .win         (win_cur),
      .count       (count_next),
      .list_select (s1_sel_ff),
      .hit         (match)
   );

   // next state of the input stage, string state and result
   always_comb begin
      s1_valid_in    = req_take || (s1_valid_ff && !advance);
      hist_in        = hist_ff;
      count_in       = count_ff;
      hit_in         = hit_ff;
      out_valid_in   = out_valid_ff && !rsp.ready;
      out_matched_in = out_matched_ff;
      if (advance) begin
         if (s1_last_ff) begin
            count_in       = '0;
            hit_in         = 1'b0;
            out_valid_in   = 1'b1;
            out_matched_in = hit_ff || match;
         end else begin
            hist_in  = win_cur[MAX_PATTERN_LEN-2:0];
            count_in = count_next;
            hit_in   = hit_ff || match;
         end
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         count_ff     <= '0;
         hit_ff       <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         count_ff     <= count_in;
         hit_ff       <= hit_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_char_ff <= fold_char(req.char_code);
         s1_last_ff <= req.is_last;
         s1_sel_ff  <= req.list_select;
      end
      hist_ff        <= hist_in;
      out_matched_ff <= out_matched_in;
   end

   assign rsp.valid   = out_valid_ff;
   assign rsp.matched = out_matched_ff;

endmodule

### rtl/mpsm_match.sv
// Parallel comparators of the character window against every fixed pattern.
// Depends on mpsm_pkg for the pattern tables.
`timescale 1ns / 1ps

module mpsm_match
   import mpsm_pkg::*;
#(
   parameter int MAX_PATTERN_LEN = MAX_PATTERN_LEN_DEF,
   localparam int CNT_W = $clog2(MAX_PATTERN_LEN + 1)
) (
   input  logic [MAX_PATTERN_LEN-1:0][CHAR_W-1:0] win,
   input  logic [CNT_W-1:0]                       count,
   input  logic                                   list_select,
   output logic                                   hit
);

   pat_mask_type pat_hit;

   // one comparator per pattern, newest byte against the last pattern character
   for (genvar p = 0; p < PAT_COUNT; p++) begin : g_pat
      if (PAT_LEN[p] <= MAX_PATTERN_LEN) begin : g_fit
         localparam int LEN = PAT_LEN[p];
         logic [LEN-1:0] eq;
         for (genvar j = 0; j < LEN; j++) begin : g_chr
            assign eq[j] = (win[j] == PAT_TEXT[p][LEN-1-j]);
         end
         assign pat_hit[p] = (count >= CNT_W'(LEN)) && (&eq);
      end else begin : g_long
         // longer than the window, never matches
         assign pat_hit[p] = 1'b0;
      end
   end

   // keep only the patterns of the chosen list
   assign hit = |(pat_hit & LIST_MASK[list_select]);

endmodule
